// ----- hw/rtl/aqs_pkg.sv -----
// announce queue scheduler package: payload structs, codes and helpers
// no dependencies
`default_nettype none
package aqs_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  msg_type;
    logic [1:0]  target;
    logic [31:0] dest_addr;
    logic [31:0] iface_addr;
    logic [15:0] dest_port;
    logic [31:0] due_time;
    logic [31:0] now_time;
  } aqs_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  out_type;
    logic [1:0]  out_target;
    logic [31:0] out_dest;
    logic [31:0] out_iface;
    logic [15:0] out_port;
    logic [30:0] out_boot;
    logic [30:0] out_next_boot;
    logic        update_pending;
    logic        last;
  } aqs_rsp_t;

  // stored entry (without valid bit)
  typedef struct packed {
    logic [1:0]  mtype;
    logic [1:0]  target;
    logic [31:0] dest;
    logic [31:0] iface;
    logic [15:0] port;
    logic [31:0] due;
    logic [30:0] boot;
    logic [30:0] next_boot;
  } aqs_entry_t;

  localparam logic [1:0] KIND_POST   = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] T_INIT   = 2'd0;
  localparam logic [1:0] T_ALIVE  = 2'd1;
  localparam logic [1:0] T_UPDATE = 2'd2;
  localparam logic [1:0] T_RESP   = 2'd3;

  localparam logic [2:0] ST_MERGED   = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_DUE      = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic       CFG_BOOT    = 1'b0;
  localparam logic       CFG_REFRESH = 1'b1;

  localparam logic [30:0] BOOT_MAX   = 31'h7fffffff;
  localparam logic [8:0]  REFRESH_MS = 9'd450;
  localparam int          MAX_RESULTS = 16;
  localparam int          RES_W       = 5;   // counts up to MAX_RESULTS

  function automatic logic [30:0] next_boot_of(input logic [30:0] b);
    return (b == BOOT_MAX) ? 31'd1 : b + 31'd1;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/announce_queue_scheduler_core.sv -----
// announce queue scheduler top level: slot table memory and scan sequencer
// depends on aqs_pkg
//
// usage
// - req channel (req_valid_i/req_ready_o/req_i): post, poll or clear requests
// - rsp channel (rsp_valid_o/rsp_ready_i/rsp_o): result items, last marks the
//   final result of a request
// - cfg channel: index 0 boot id, 1 refresh interval; taken only while idle and
//   ahead of a request offered in the same cycle
// - entries sit in one synchronous memory (registered read); valid
//   bits and type copies per slot live in flip-flops
// - a post reads slot by slot until a match or the end, then loads the result
// - a poll first scans every slot to mark due entries and work out the
//   pending-update flag, then reads and emits each due entry in turn, or
//   gives a single none-due result
// - a clear gives one cleared result, an unknown kind gives no result
// - one request is worked on at a time; emitting pauses while a result
//   waits in the output register, so a stalled receiver stalls the input
// - reset empties the table at once through the valid bits, boot id 1,
//   interval 1800
`default_nettype none
module announce_queue_scheduler_core #(
  parameter int SLOTS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire aqs_pkg::aqs_req_t req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output aqs_pkg::aqs_rsp_t    rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import aqs_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POST = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  // entry memory
  aqs_entry_t mem [SLOTS];
  aqs_entry_t rd_q;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  aqs_entry_t wr_data;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] upd_q, upd_d;     // slot holds an update
  logic [SLOTS-1:0] resp_q, resp_d;   // slot holds a response
  logic [SLOTS-1:0] dmask_q, dmask_d; // due slots still to emit

  logic [30:0] boot_q;
  logic [16:0] refresh_q;
  logic [31:0] period_q; // refresh interval times 450

  aqs_req_t req_q;
  logic req_acc;
  logic [CW-1:0] cnt_q, cnt_d;   // slots read so far
  logic [CW-1:0] cnt_m1;
  logic [RES_W-1:0] ndue_q, ndue_d;
  logic [RES_W-1:0] nres_q, nres_d;
  logic pend_q, pend_d;          // update left in the table after the poll
  logic [2:0] status_q, status_d;
  logic [IW-1:0] at_q, at_d;

  aqs_rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;
  logic out_free;

  logic [IW-1:0] cur;
  logic [IW-1:0] lo_free, lo_resp, lo_due;
  logic any_free, any_resp;
  logic match;
  logic due_now;
  logic [31:0] dd;
  logic [31:0] md;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // rd_q holds slot cnt_q-1 while scanning
  assign cnt_m1 = cnt_q - CW'(1);
  assign cur = cnt_m1[IW-1:0];

  // lowest free, response and due slot from the flag bits
  always_comb begin
    lo_free = '0;
    lo_resp = '0;
    lo_due = '0;
    any_free = 1'b0;
    any_resp = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        lo_free = IW'(i);
        any_free = 1'b1;
      end
      if (valid_q[i] && resp_q[i]) begin
        lo_resp = IW'(i);
        any_resp = 1'b1;
      end
      if (dmask_q[i]) begin
        lo_due = IW'(i);
      end
    end
  end

  assign match = valid_q[cur] && (req_q.msg_type != T_INIT) &&
                 rd_q.mtype == req_q.msg_type && rd_q.target == req_q.target &&
                 rd_q.dest == req_q.dest_addr && rd_q.iface == req_q.iface_addr &&
                 rd_q.port == req_q.dest_port;
  assign dd = req_q.now_time - rd_q.due;
  assign due_now = valid_q[cur] && !dd[31];
  assign md = rd_q.due - req_q.due_time;

  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign req_acc = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ndue_d = ndue_q;
    nres_d = nres_q;
    pend_d = pend_q;
    status_d = status_q;
    at_d = at_q;
    valid_d = valid_q;
    upd_d = upd_q;
    resp_d = resp_q;
    dmask_d = dmask_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rd_addr = cnt_q[IW-1:0];
    wr_en = 1'b0;
    wr_addr = at_q;
    wr_data = rd_q;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        cnt_d = CW'(1);
        if (req_acc) begin
          unique case (req_i.kind)
            KIND_POST: begin
              state_d = S_POST;
            end
            KIND_POLL: begin
              state_d = S_SCAN;
              dmask_d = '0;
              ndue_d = '0;
              nres_d = '0;
              pend_d = 1'b0;
            end
            KIND_CLEAR: begin
              valid_d = '0;
              status_d = ST_CLEARED;
              state_d = S_FIN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POST: begin
        wr_data.boot = boot_q;
        wr_data.next_boot = (req_q.msg_type == T_UPDATE) ?
                            next_boot_of(boot_q) : 31'd0;
        if (match) begin
          // merge: keep the earlier due time, restamp boot ids
          wr_en = 1'b1;
          wr_addr = cur;
          if (md != 32'd0 && !md[31]) wr_data.due = req_q.due_time;
          status_d = ST_MERGED;
          state_d = S_FIN;
        end else if (cnt_q == CW'(SLOTS)) begin
          wr_data.mtype = req_q.msg_type;
          wr_data.target = req_q.target;
          wr_data.dest = req_q.dest_addr;
          wr_data.iface = req_q.iface_addr;
          wr_data.port = req_q.dest_port;
          wr_data.due = req_q.due_time;
          state_d = S_FIN;
          if (any_free) begin
            wr_en = 1'b1;
            wr_addr = lo_free;
            status_d = ST_STORED;
          end else if (req_q.msg_type != T_RESP && any_resp) begin
            wr_en = 1'b1;
            wr_addr = lo_resp;
            status_d = ST_REPLACED;
          end else begin
            status_d = ST_DROPPED;
          end
          if (wr_en) begin
            valid_d[wr_addr] = 1'b1;
            upd_d[wr_addr] = req_q.msg_type == T_UPDATE;
            resp_d[wr_addr] = req_q.msg_type == T_RESP;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_SCAN: begin
        // mark due slots up to the result cap; updates that stay set the flag
        if (due_now && ndue_q != RES_W'(MAX_RESULTS)) begin
          dmask_d[cur] = 1'b1;
          ndue_d = ndue_q + RES_W'(1);
        end else if (valid_q[cur] && upd_q[cur]) begin
          pend_d = 1'b1;
        end
        if (cnt_q == CW'(SLOTS)) begin
          if (ndue_d == '0) begin
            status_d = ST_NONE;
            state_d = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_RD: begin
        rd_addr = lo_due;
        at_d = lo_due;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        rd_addr = at_q; // keep rd_q on this slot while stalled
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d = '0;
          rsp_d.status = ST_DUE;
          rsp_d.out_type = rd_q.mtype;
          rsp_d.out_target = rd_q.target;
          rsp_d.out_dest = rd_q.dest;
          rsp_d.out_iface = rd_q.iface;
          rsp_d.out_port = rd_q.port;
          rsp_d.out_boot = (rd_q.mtype == T_UPDATE) ? rd_q.boot : boot_q;
          rsp_d.out_next_boot = (rd_q.mtype == T_UPDATE) ? rd_q.next_boot : 31'd0;
          rsp_d.update_pending = pend_q;
          rsp_d.last = (nres_q + RES_W'(1) == ndue_q);
          if (rd_q.mtype == T_ALIVE) begin
            wr_en = 1'b1;
            wr_addr = at_q;
            wr_data.due = req_q.now_time + period_q;
          end else begin
            valid_d[at_q] = 1'b0;
          end
          dmask_d[at_q] = 1'b0;
          nres_d = nres_q + RES_W'(1);
          state_d = rsp_d.last ? S_IDLE : S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          rsp_d = '0;
          rsp_d.status = status_q;
          rsp_d.update_pending = |(valid_q & upd_q);
          rsp_d.last = 1'b1;
          rsp_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      dmask_q <= '0;
      rsp_valid_q <= 1'b0;
      cnt_q <= '0;
      ndue_q <= '0;
      nres_q <= '0;
      pend_q <= 1'b0;
      boot_q <= 31'd1;
      refresh_q <= 17'd1800;
      period_q <= 32'd810000;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dmask_q <= dmask_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q <= cnt_d;
      ndue_q <= ndue_d;
      nres_q <= nres_d;
      pend_q <= pend_d;
      period_q <= 32'(refresh_q) * 32'(REFRESH_MS);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BOOT) boot_q <= cfg_data_i[30:0];
        else refresh_q <= cfg_data_i[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    upd_q <= upd_d;
    resp_q <= resp_d;
    if (req_acc) req_q <= req_i;
    status_q <= status_d;
    at_q <= at_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> state_q == S_IDLE)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POST || state_q == S_SCAN) |-> cnt_q != '0 && cnt_q <= CW'(SLOTS))
    else $error("scan ran past the table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndue_q <= RES_W'(MAX_RESULTS) && nres_q <= ndue_q)
    else $error("due count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> dmask_q[at_q])
    else $error("emitting a slot that is not due");
endmodule
`default_nettype wire
